// ===== rtl/core/irc_pkg.sv =====
// shared types and constants for the iteration rainbow color map
// segment codes, the rgb item layout and the segment-to-color decode
// no dependencies
package irc_pkg;

    localparam int FIELD_BITS = 16;
    localparam int CHAN_BITS  = 8;
    localparam int SEG_BITS   = 3;
    localparam int RAMP_BITS  = 8;

    localparam logic [CHAN_BITS-1:0] RAMP_TOP = 8'd255;
    localparam logic [FIELD_BITS-1:0] MAX_ITER_RESET = 16'd1000;

    // one code per ramp segment; any other code decodes to pure red
    localparam logic [SEG_BITS-1:0] SEG_RED_YELLOW    = 3'd0;
    localparam logic [SEG_BITS-1:0] SEG_YELLOW_GREEN  = 3'd1;
    localparam logic [SEG_BITS-1:0] SEG_GREEN_CYAN    = 3'd2;
    localparam logic [SEG_BITS-1:0] SEG_CYAN_BLUE     = 3'd3;
    localparam logic [SEG_BITS-1:0] SEG_BLUE_MAGENTA  = 3'd4;
    localparam logic [SEG_BITS-1:0] SEG_MAGENTA_RED   = 3'd5;

    // first member sits in the high bits, so red lands in bits 7:0
    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
    } rgb_t;

    function automatic rgb_t seg_to_rgb(input logic [SEG_BITS-1:0] seg,
                                        input logic [RAMP_BITS-1:0] ramp);
        rgb_t c;
        c = '{blue: '0, green: '0, red: RAMP_TOP};
        unique case (seg)
            SEG_RED_YELLOW:   c = '{blue: '0, green: ramp, red: RAMP_TOP};
            SEG_YELLOW_GREEN: c = '{blue: '0, green: RAMP_TOP, red: RAMP_TOP - ramp};
            SEG_GREEN_CYAN:   c = '{blue: ramp, green: RAMP_TOP, red: '0};
            SEG_CYAN_BLUE:    c = '{blue: RAMP_TOP, green: RAMP_TOP - ramp, red: '0};
            SEG_BLUE_MAGENTA: c = '{blue: RAMP_TOP, green: '0, red: ramp};
            SEG_MAGENTA_RED:  c = '{blue: RAMP_TOP - ramp, green: '0, red: RAMP_TOP};
            default:          c = '{blue: '0, green: '0, red: RAMP_TOP};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/irc_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per register stage
// carries a sideband vector and a valid bit alongside each item
// depends on nothing; the user must hold the divisor stable while items are in flight, the block does not enforce it
module irc_div_pipe #(
    parameter int NUM_BITS  = 16,
    parameter int DIV_BITS  = 16,
    parameter int QUO_BITS  = 16,
    parameter int SIDE_BITS = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  in_num,
    input  logic [SIDE_BITS-1:0] in_side,
    input  logic [DIV_BITS-1:0]  divisor,
    output logic                 out_valid,
    output logic [QUO_BITS-1:0]  out_quo,
    output logic [NUM_BITS-1:0]  out_rem,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int EXT_BITS = NUM_BITS + DIV_BITS;

    logic                 valid_reg [QUO_BITS];
    logic [NUM_BITS-1:0]  rem_reg   [QUO_BITS];
    logic [QUO_BITS-1:0]  quo_reg   [QUO_BITS];
    logic [SIDE_BITS-1:0] side_reg  [QUO_BITS];

    logic [EXT_BITS-1:0] div_ext;
    assign div_ext = {{NUM_BITS{1'b0}}, divisor};

    for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
        localparam int SHIFT = QUO_BITS - 1 - i;

        logic                 prev_valid;
        logic [NUM_BITS-1:0]  prev_rem;
        logic [QUO_BITS-1:0]  prev_quo;
        logic [SIDE_BITS-1:0] prev_side;
        logic [EXT_BITS-1:0]  rem_ext;
        logic [EXT_BITS-1:0]  div_sh;
        logic [EXT_BITS-1:0]  diff;
        logic                 take;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_num;
            assign prev_quo   = '0;
            assign prev_side  = in_side;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_rem   = rem_reg[i-1];
            assign prev_quo   = quo_reg[i-1];
            assign prev_side  = side_reg[i-1];
        end

        assign rem_ext = {{DIV_BITS{1'b0}}, prev_rem};
        assign div_sh  = div_ext << SHIFT;
        assign take    = (rem_ext >= div_sh);
        assign diff    = rem_ext - div_sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? diff[NUM_BITS-1:0] : prev_rem;
                quo_reg[i]  <= prev_quo | (QUO_BITS'(take) << SHIFT);
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[QUO_BITS-1];
    assign out_quo   = quo_reg[QUO_BITS-1];
    assign out_rem   = rem_reg[QUO_BITS-1];
    assign out_side  = side_reg[QUO_BITS-1];

endmodule

// ===== rtl/core/iteration_rainbow_color_map.sv =====
// iteration rainbow color map: iteration count in, rgb item out
// three pipelined dividers (wrap, segment, ramp) and a color decode stage
// depends on irc_pkg and irc_div_pipe
//
// usage:
//   s_tdata carries one iteration count per item; m_tdata returns one color
//   per item. max_iterations is written through cfg_wr_en / cfg_wr_data;
//   the user must write it only while no item is in flight, and the block
//   does not enforce it. a maximum of zero gives pure red. throughput:
//   one item per cycle unless the output stalls. the CW stages come from the
//   wrap divider, one quotient bit per stage, CW being the smaller of
//   COUNT_BITS and 16, then 3 segment stages, 8 ramp stages and three registers.
//   reset clears all valid bits and sets max_iterations to 1000; items in
//   flight at reset are dropped. while m_tvalid is high and m_tready low the
//   whole pipeline holds, and s_tready falls in the same cycle.
module iteration_rainbow_color_map
    import irc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // max_iterations
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // iteration_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // red [7:0], green [15:8], blue [23:16]
);

    localparam int CW = (COUNT_BITS < FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam int SCALED_BITS = CW + SEG_BITS;
    localparam int PROD_BITS   = CW + RAMP_BITS;

    logic [CW-1:0] max_iter_reg;
    logic          en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET[CW-1:0];
        end else if (cfg_wr_en) begin
            max_iter_reg <= cfg_wr_data[CW-1:0];
        end
    end

    logic m_tvalid_reg;
    rgb_t m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // wrap stage: count mod max, only the remainder is kept
    logic [CW-1:0] a_in;
    logic          a_gt;
    logic          b_zero;
    logic          wrap_valid;
    logic [CW-1:0] wrap_rem;
    logic [CW+1:0] wrap_side;

    assign a_in   = s_tdata[CW-1:0];
    assign a_gt   = (a_in > max_iter_reg);
    assign b_zero = (max_iter_reg == '0);

    irc_div_pipe #(
        .NUM_BITS (CW),
        .DIV_BITS (CW),
        .QUO_BITS (CW),
        .SIDE_BITS(CW + 2)
    ) u_wrap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_num   (a_in),
        .in_side  ({a_in, a_gt, b_zero}),
        .divisor  (max_iter_reg),
        .out_valid(wrap_valid),
        .out_quo  (),
        .out_rem  (wrap_rem),
        .out_side (wrap_side)
    );

    // fixup: an exact multiple maps to the end of the ramp, then scale by 6
    logic [CW-1:0]          a_red;
    logic                   fix_valid_reg;
    logic [SCALED_BITS-1:0] scaled_reg;
    logic                   fix_zero_reg;

    always_comb begin
        if (wrap_side[1]) begin
            a_red = (wrap_rem == '0) ? max_iter_reg : wrap_rem;
        end else begin
            a_red = wrap_side[CW+1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fix_valid_reg <= 1'b0;
        end else if (en) begin
            fix_valid_reg <= wrap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scaled_reg   <= {1'b0, a_red, 2'b00} + {2'b00, a_red, 1'b0};
            fix_zero_reg <= wrap_side[0];
        end
    end

    // segment stage: floor(6a / b), quotient 0..6
    logic                   seg_valid;
    logic [SEG_BITS-1:0]    seg_quo;
    logic [SCALED_BITS-1:0] seg_rem;
    logic                   seg_zero;

    irc_div_pipe #(
        .NUM_BITS (SCALED_BITS),
        .DIV_BITS (CW),
        .QUO_BITS (SEG_BITS),
        .SIDE_BITS(1)
    ) u_seg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fix_valid_reg),
        .in_num   (scaled_reg),
        .in_side  (fix_zero_reg),
        .divisor  (max_iter_reg),
        .out_valid(seg_valid),
        .out_quo  (seg_quo),
        .out_rem  (seg_rem),
        .out_side (seg_zero)
    );

    // remainder times 255, as (rem << 8) - rem; rem is below b
    logic                  prod_valid_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [SEG_BITS-1:0]   prod_seg_reg;
    logic                  prod_zero_reg;
    logic [CW-1:0]         rem_c;

    assign rem_c = seg_rem[CW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= {rem_c, {RAMP_BITS{1'b0}}} - {{RAMP_BITS{1'b0}}, rem_c};
            prod_seg_reg  <= seg_quo;
            prod_zero_reg <= seg_zero;
        end
    end

    // ramp stage: floor(rem * 255 / b)
    logic                  ramp_valid;
    logic [RAMP_BITS-1:0]  ramp_quo;
    logic [SEG_BITS:0]     ramp_side;

    irc_div_pipe #(
        .NUM_BITS (PROD_BITS),
        .DIV_BITS (CW),
        .QUO_BITS (RAMP_BITS),
        .SIDE_BITS(SEG_BITS + 1)
    ) u_ramp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (prod_valid_reg),
        .in_num   (prod_reg),
        .in_side  ({prod_seg_reg, prod_zero_reg}),
        .divisor  (max_iter_reg),
        .out_valid(ramp_valid),
        .out_quo  (ramp_quo),
        .out_rem  (),
        .out_side (ramp_side)
    );

    // color decode into the output register
    rgb_t m_tdata_next;

    always_comb begin
        if (ramp_side[0]) begin
            m_tdata_next = '{blue: '0, green: '0, red: RAMP_TOP};
        end else begin
            m_tdata_next = seg_to_rgb(ramp_side[SEG_BITS:1], ramp_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ramp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
